### rtl/ovls_pkg.sv
// Shared types and codes for the ordered value list store.
package ovls_pkg;

    typedef enum logic [1:0] {
        KIND_INS_FRONT = 2'd0,
        KIND_INS_BACK  = 2'd1,
        KIND_DELETE    = 2'd2,
        KIND_SEARCH    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    localparam int ITEM_VALUE_WIDTH = 32;
    localparam int ENTRY_COUNT_WIDTH = 5;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic  compare_en;
        logic  apply;
        kind_t kind;
    } cell_ctrl_t;

endpackage

### rtl/ovls_req_if.sv
// Request channel: operation kind and value, with valid/ready handshake.
interface ovls_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           kind;
    logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] item_value;

    modport source (output valid, output kind, output item_value, input ready);
    modport sink   (input valid, input kind, input item_value, output ready);
endinterface

### rtl/ovls_rsp_if.sv
// Response channel: found flag, status and entry count, with valid/ready handshake.
interface ovls_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  found;
    logic [1:0]                            status;
    logic [ovls_pkg::ENTRY_COUNT_WIDTH-1:0] entry_count;

    modport source (output valid, output found, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input found, input status, input entry_count,
                    output ready);
endinterface

### rtl/ovls_cell.sv
// One list position: holds a value, compares it with the key and shifts with its neighbours.
module ovls_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 5,
    parameter int INDEX       = 0
) (
    input  logic                      clk,
    input  ovls_pkg::cell_ctrl_t      ctrl,
    input  logic [VALUE_WIDTH-1:0]    key,
    input  logic [COUNT_WIDTH-1:0]    count,
    input  logic [VALUE_WIDTH-1:0]    left_value,
    input  logic [VALUE_WIDTH-1:0]    right_value,
    input  logic                      hit_in,
    output logic [VALUE_WIDTH-1:0]    value,
    output logic                      hit_out
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   match_reg;
    logic                   occupied;

    assign occupied = COUNT_WIDTH'(INDEX) < count;
    assign value    = value_reg;

    // A cell at or behind the first match sees hit_out high and, on a delete, pulls from its right.
    assign hit_out = hit_in | match_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.kind)
            ovls_pkg::KIND_INS_FRONT:
            begin
                value_next = (INDEX == 0) ? key : left_value;
            end
            ovls_pkg::KIND_INS_BACK:
            begin
                if (COUNT_WIDTH'(INDEX) == count)
                begin
                    value_next = key;
                end
            end
            ovls_pkg::KIND_DELETE:
            begin
                if (hit_out)
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.compare_en)
        begin
            match_reg <= occupied && (value_reg == key);
        end
        if (ctrl.apply)
        begin
            value_reg <= value_next;
        end
    end

endmodule

### rtl/ordered_value_list_store.sv
// Ordered value list store: a row of cells kept front first, with a small controller.
// A request transfer moves the controller to its execute state, and the result is
// registered as that state finishes, never together with the request transfer.
// A new request is taken only in the idle state, once the compare step and the
// first-match ripple plus update step over the row of cells have finished.
// The controller waits in its execute cycle while an earlier result is still held.
// Reset (rst_n low, asynchronous) empties the list and clears the result valid.
module ordered_value_list_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ovls_req_if.sink     req,
    ovls_rsp_if.source   rsp
);

    localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

    ovls_pkg::state_t        state_reg;
    ovls_pkg::state_t        state_next;
    ovls_pkg::kind_t         kind_reg;
    logic [VALUE_WIDTH-1:0]  key_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [COUNT_WIDTH-1:0]  count_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    found_reg;
    logic                    found_next;
    ovls_pkg::status_t       status_reg;
    ovls_pkg::status_t       status_next;
    logic [COUNT_WIDTH-1:0]  out_count_reg;

    ovls_pkg::cell_ctrl_t    cell_ctrl;
    logic [VALUE_WIDTH-1:0]  key;
    logic [VALUE_WIDTH-1:0]  cell_value [DEPTH];
    logic [DEPTH:0]          hit_chain;
    logic                    req_xfer;
    logic                    can_finish;
    logic                    finish;
    logic                    full;
    logic                    empty;
    logic                    any_hit;
    logic                    changes;

    assign req_xfer   = req.valid && req.ready;
    assign can_finish = !out_valid_reg || rsp.ready;
    assign finish     = (state_reg == ovls_pkg::ST_EXEC) && can_finish;
    assign full       = count_reg == COUNT_WIDTH'(DEPTH);
    assign empty      = count_reg == '0;
    assign any_hit    = hit_chain[DEPTH];
    assign key        = (state_reg == ovls_pkg::ST_IDLE) ? VALUE_WIDTH'(req.item_value)
                                                         : key_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ovls_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ovls_pkg::ST_EXEC;
                end
            end
            ovls_pkg::ST_EXEC:
            begin
                if (can_finish)
                begin
                    state_next = ovls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ovls_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        req.ready            = 1'b0;
        cell_ctrl.compare_en = 1'b0;
        cell_ctrl.apply      = 1'b0;
        cell_ctrl.kind       = kind_reg;
        case (state_reg)
            ovls_pkg::ST_IDLE:
            begin
                req.ready            = 1'b1;
                cell_ctrl.compare_en = req_xfer;
            end
            ovls_pkg::ST_EXEC:
            begin
                cell_ctrl.apply = can_finish && changes;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Result of the operation held in kind_reg and key_reg.
    always_comb
    begin
        found_next  = 1'b0;
        status_next = ovls_pkg::STATUS_DONE;
        count_next  = count_reg;
        changes     = 1'b0;
        case (kind_reg)
            ovls_pkg::KIND_INS_FRONT, ovls_pkg::KIND_INS_BACK:
            begin
                if (full)
                begin
                    status_next = ovls_pkg::STATUS_FULL;
                end
                else
                begin
                    changes    = 1'b1;
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end
            ovls_pkg::KIND_DELETE:
            begin
                if (empty)
                begin
                    status_next = ovls_pkg::STATUS_EMPTY;
                end
                else if (any_hit)
                begin
                    found_next = 1'b1;
                    changes    = 1'b1;
                    count_next = count_reg - COUNT_WIDTH'(1);
                end
                else
                begin
                    status_next = ovls_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status_next = ovls_pkg::STATUS_EMPTY;
                end
                else if (any_hit)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    status_next = ovls_pkg::STATUS_NOT_FOUND;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovls_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            kind_reg <= ovls_pkg::kind_t'(req.kind);
            key_reg  <= VALUE_WIDTH'(req.item_value);
        end
        if (finish)
        begin
            found_reg     <= found_next;
            status_reg    <= status_next;
            out_count_reg <= count_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = ovls_pkg::ENTRY_COUNT_WIDTH'(out_count_reg);

    // The first-match flag ripples from the front of the row to the back.
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ovls_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .INDEX       (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .key         (key),
            .count       (count_reg),
            .left_value  ((i == 0) ? key : cell_value[(i == 0) ? 0 : i - 1]),
            .right_value (cell_value[(i == DEPTH - 1) ? i : i + 1]),
            .hit_in      (hit_chain[i]),
            .value       (cell_value[i]),
            .hit_out     (hit_chain[i + 1])
        );
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_WIDTH'(DEPTH))
        else $error("entry count exceeds the list depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> state_reg == ovls_pkg::ST_EXEC)
        else $error("request transfer did not start an execute cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ovls_pkg::ST_EXEC && out_valid_reg && !rsp.ready)
        |=> state_reg == ovls_pkg::ST_EXEC && $stable(count_reg))
        else $error("operation completed while the previous result was held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && kind_reg == ovls_pkg::KIND_DELETE && any_hit)
        |=> count_reg == $past(count_reg) - COUNT_WIDTH'(1))
        else $error("successful delete did not shorten the list by one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (finish && kind_reg == ovls_pkg::KIND_SEARCH) |=> $stable(count_reg))
        else $error("search changed the entry count");

endmodule

### sim/ordered_value_list_store_tb.sv
// Self-checking testbench for the ordered value list store.
`timescale 1ns / 100ps

module ordered_value_list_store_tb;

    localparam int LIST_DEPTH = 16;
    localparam int POOL_SIZE = 8;
    localparam int PHASE_ITEMS = 500;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        ovls_pkg::kind_t                       kind;
        logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] value;
    } list_op_t;

    typedef struct {
        logic                                   found;
        ovls_pkg::status_t                      status;
        logic [ovls_pkg::ENTRY_COUNT_WIDTH-1:0] count;
    } list_reply_t;

    logic clk;
    logic rst_n;

    ovls_req_if req_ch ();
    ovls_rsp_if rsp_ch ();

    ordered_value_list_store #(
        .DEPTH       (LIST_DEPTH),
        .VALUE_WIDTH (ovls_pkg::ITEM_VALUE_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_op_t                              pending_ops[$];
    list_reply_t                           expected_replies[$];
    logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] list_vals[LIST_DEPTH];
    int                                    list_len;
    logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] value_pool[POOL_SIZE];
    int                                    send_idle_pct;
    int                                    recv_stall_pct;
    int                                    hold_cycles;
    int                                    error_count;
    bit                                    req_fired;

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Updates the list copy with one operation and returns the reply it produces.
    function automatic list_reply_t apply_list_op(list_op_t op);
        list_reply_t r;
        int          pos;
        int          i;
        r.found  = 1'b0;
        r.status = ovls_pkg::STATUS_DONE;
        pos      = -1;
        case (op.kind)
            ovls_pkg::KIND_INS_FRONT, ovls_pkg::KIND_INS_BACK:
            begin
                if (list_len >= LIST_DEPTH)
                    r.status = ovls_pkg::STATUS_FULL;
                else if (op.kind == ovls_pkg::KIND_INS_FRONT)
                begin
                    for (i = list_len; i > 0; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[0] = op.value;
                    list_len++;
                end
                else
                begin
                    list_vals[list_len] = op.value;
                    list_len++;
                end
            end
            default:
            begin
                if (list_len == 0)
                    r.status = ovls_pkg::STATUS_EMPTY;
                else
                begin
                    for (i = 0; i < list_len; i++)
                        if (pos < 0 && list_vals[i] == op.value)
                            pos = i;
                    if (pos < 0)
                        r.status = ovls_pkg::STATUS_NOT_FOUND;
                    else
                    begin
                        r.found = 1'b1;
                        if (op.kind == ovls_pkg::KIND_DELETE)
                        begin
                            for (i = pos; i + 1 < list_len; i++)
                                list_vals[i] = list_vals[i+1];
                            list_len--;
                        end
                    end
                end
            end
        endcase
        r.count = list_len[ovls_pkg::ENTRY_COUNT_WIDTH-1:0];
        return r;
    endfunction

    // Request driver: a held item stays on the bus until its transfer.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fired)
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                list_op_t op;
                op = pending_ops.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.kind       <= op.kind;
                req_ch.item_value <= op.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response ready, with an optional long hold-off counted down here.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: responses are checked before a new request is predicted.
    always @(posedge clk)
    begin
        req_fired = 1'b0;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("response with no request outstanding");
                    error_count++;
                end
                else
                begin
                    list_reply_t want;
                    want = expected_replies.pop_front();
                    if (rsp_ch.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                        error_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        error_count++;
                    end
                    if (rsp_ch.entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, rsp_ch.entry_count);
                        error_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                list_op_t op;
                req_fired = 1'b1;
                op.kind  = ovls_pkg::kind_t'(req_ch.kind);
                op.value = req_ch.item_value;
                expected_replies.push_back(apply_list_op(op));
            end
        end
    end

    task automatic queue_op(ovls_pkg::kind_t kind,
                            logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] value);
        list_op_t op;
        op.kind  = kind;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    // Values mostly come from a small pool so that deletes and searches hit,
    // with the occasional fully random value to exercise every bit.
    task automatic queue_random_ops(int n);
        bit                                    growing;
        int                                    r;
        ovls_pkg::kind_t                       kind;
        logic [ovls_pkg::ITEM_VALUE_WIDTH-1:0] value;
        growing = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                growing = $urandom_range(1);
            r = $urandom_range(99);
            if (growing)
                kind = (r < 35) ? ovls_pkg::KIND_INS_FRONT :
                       (r < 70) ? ovls_pkg::KIND_INS_BACK :
                       (r < 85) ? ovls_pkg::KIND_DELETE : ovls_pkg::KIND_SEARCH;
            else
                kind = (r < 15) ? ovls_pkg::KIND_INS_FRONT :
                       (r < 30) ? ovls_pkg::KIND_INS_BACK :
                       (r < 80) ? ovls_pkg::KIND_DELETE : ovls_pkg::KIND_SEARCH;
            if ($urandom_range(99) < 80)
                value = value_pool[$urandom_range(POOL_SIZE-1)];
            else
                value = $urandom;
            queue_op(kind, value);
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || req_ch.valid || expected_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int hold);
        @(posedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_cycles    = hold;
        queue_random_ops(PHASE_ITEMS);
        wait_drained();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = ovls_pkg::KIND_INS_FRONT;
        req_ch.item_value = '0;
        rsp_ch.ready      = 1'b0;
        req_fired         = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_cycles       = 0;
        error_count       = 0;
        list_len          = 0;
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty list, a back insert that becomes the front, duplicates,
        // misses, then filling to the brim and overflowing at both ends.
        queue_op(ovls_pkg::KIND_DELETE, 32'd5);
        queue_op(ovls_pkg::KIND_SEARCH, 32'd5);
        queue_op(ovls_pkg::KIND_INS_BACK, 32'hFFFF_FFFF);
        queue_op(ovls_pkg::KIND_SEARCH, 32'hFFFF_FFFF);
        queue_op(ovls_pkg::KIND_INS_FRONT, 32'h0000_0000);
        queue_op(ovls_pkg::KIND_INS_BACK, 32'h0000_0000);
        queue_op(ovls_pkg::KIND_DELETE, 32'h0000_0000);
        queue_op(ovls_pkg::KIND_SEARCH, 32'h0000_0000);
        queue_op(ovls_pkg::KIND_DELETE, 32'd7);
        queue_op(ovls_pkg::KIND_SEARCH, 32'd7);
        for (int i = 0; i < 14; i++)
            queue_op((i % 2) ? ovls_pkg::KIND_INS_BACK : ovls_pkg::KIND_INS_FRONT,
                     (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
        queue_op(ovls_pkg::KIND_INS_FRONT, 32'h1234_5678);
        queue_op(ovls_pkg::KIND_INS_BACK, 32'h1234_5678);
        queue_op(ovls_pkg::KIND_SEARCH, 32'h5555_5555 ^ 12);
        wait_drained();

        // The first phase holds the receiver off long enough to back up the input.
        run_phase(0, 0, 300);
        run_phase(74, 0, 0);
        run_phase(0, 74, 0);
        run_phase(27, 27, 0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
